// ===== hdl/kscg_pkg.sv =====
// kscg_pkg: shared types, constants and the microcode ROM of the
// k-subset combination generator. No dependencies.

package kscg_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int MAX_SUBSET   = 16;
    localparam int VALUE_BITS   = 16;
    localparam int IDX_BITS     = 4;
    localparam int SIZE_BITS    = 5;
    localparam int PC_BITS      = 4;

    typedef logic [PC_BITS-1:0]   t_pc;
    typedef logic [SIZE_BITS-1:0] t_size;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_ADVANCE = 2'd2
    } t_cmd;

    typedef enum logic [0:0] {
        CFG_PICK_COUNT = 1'b0,
        CFG_SET_SIZE   = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_ELEM,
        EM_EMPTY,
        EM_FIN
    } t_emit;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC,
        PTR_KM1
    } t_ptr_op;

    typedef enum logic [1:0] {
        V_HOLD,
        V_LOAD,
        V_INC
    } t_v_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_DONE,
        C_KZERO,
        C_LASTP,
        C_ATMAX,
        C_PZERO
    } t_cond;

    typedef struct packed {
        t_emit   emit;
        t_ptr_op ptr_op;
        logic    pos_wr;
        t_v_op   v_op;
        logic    set_done;
        t_cond   cond;
        logic    inv;
        t_pc     target;
        logic    fin;
    } t_ctrl;

    typedef struct packed {
        logic done;
        logic kzero;
        logic lastp;
        logic atmax;
        logic pzero;
    } t_flags;

    localparam t_pc PC_DISPATCH = 4'd0;
    localparam t_pc PC_KCHECK   = 4'd1;
    localparam t_pc PC_EMIT     = 4'd2;
    localparam t_pc PC_SRCH_INI = 4'd3;
    localparam t_pc PC_SRCH     = 4'd4;
    localparam t_pc PC_SRCH_END = 4'd5;
    localparam t_pc PC_SRCH_DEC = 4'd6;
    localparam t_pc PC_FOUND    = 4'd7;
    localparam t_pc PC_FILL     = 4'd8;
    localparam t_pc PC_SETDONE  = 4'd9;
    localparam t_pc PC_FIN      = 4'd10;
    localparam t_pc PC_EMPTY    = 4'd11;

    localparam t_ctrl CTRL_NOP = '{emit: EM_NONE, ptr_op: PTR_HOLD, pos_wr: 1'b0,
                                   v_op: V_HOLD, set_done: 1'b0, cond: C_NEVER,
                                   inv: 1'b0, target: PC_DISPATCH, fin: 1'b1};

    function automatic t_ctrl f_w(t_emit em, t_ptr_op po, logic pw, t_v_op vo,
                                  logic sd, t_cond c, logic iv, t_pc tg, logic fn);
        t_ctrl w;
        w.emit     = em;
        w.ptr_op   = po;
        w.pos_wr   = pw;
        w.v_op     = vo;
        w.set_done = sd;
        w.cond     = c;
        w.inv      = iv;
        w.target   = tg;
        w.fin      = fn;
        return w;
    endfunction

    // conditional jump to target; otherwise end if fin, else fall through
    function automatic t_ctrl f_ucode(t_pc pc);
        t_ctrl w;
        case (pc)
            PC_DISPATCH: w = f_w(EM_NONE,  PTR_ZERO, 1'b0, V_HOLD, 1'b0,
                                 C_DONE,   1'b0, PC_FIN,      1'b0);
            PC_KCHECK:   w = f_w(EM_NONE,  PTR_HOLD, 1'b0, V_HOLD, 1'b0,
                                 C_KZERO,  1'b0, PC_EMPTY,    1'b0);
            PC_EMIT:     w = f_w(EM_ELEM,  PTR_INC,  1'b0, V_HOLD, 1'b0,
                                 C_LASTP,  1'b1, PC_EMIT,     1'b0);
            PC_SRCH_INI: w = f_w(EM_NONE,  PTR_KM1,  1'b0, V_HOLD, 1'b0,
                                 C_NEVER,  1'b0, PC_DISPATCH, 1'b0);
            PC_SRCH:     w = f_w(EM_NONE,  PTR_HOLD, 1'b0, V_HOLD, 1'b0,
                                 C_ATMAX,  1'b1, PC_FOUND,    1'b0);
            PC_SRCH_END: w = f_w(EM_NONE,  PTR_HOLD, 1'b0, V_HOLD, 1'b0,
                                 C_PZERO,  1'b0, PC_SETDONE,  1'b0);
            PC_SRCH_DEC: w = f_w(EM_NONE,  PTR_DEC,  1'b0, V_HOLD, 1'b0,
                                 C_ALWAYS, 1'b0, PC_SRCH,     1'b0);
            PC_FOUND:    w = f_w(EM_NONE,  PTR_HOLD, 1'b0, V_LOAD, 1'b0,
                                 C_NEVER,  1'b0, PC_DISPATCH, 1'b0);
            PC_FILL:     w = f_w(EM_NONE,  PTR_INC,  1'b1, V_INC,  1'b0,
                                 C_LASTP,  1'b1, PC_FILL,     1'b1);
            PC_SETDONE:  w = f_w(EM_NONE,  PTR_HOLD, 1'b0, V_HOLD, 1'b1,
                                 C_NEVER,  1'b0, PC_DISPATCH, 1'b1);
            PC_FIN:      w = f_w(EM_FIN,   PTR_HOLD, 1'b0, V_HOLD, 1'b0,
                                 C_NEVER,  1'b0, PC_DISPATCH, 1'b1);
            PC_EMPTY:    w = f_w(EM_EMPTY, PTR_HOLD, 1'b0, V_HOLD, 1'b1,
                                 C_NEVER,  1'b0, PC_DISPATCH, 1'b1);
            default:     w = CTRL_NOP;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/k_subset_combination_generator.sv =====
// k_subset_combination_generator: top level, walks k-subsets of a loaded
// table in lexicographic order. Depends on kscg_pkg, kscg_sequencer, kscg_datapath.
//
// Usage:
//   A request is taken at a clock edge with start high and busy low.
//   cmd LOAD writes element_value into table slot element_index; cmd RESTART
//   latches the clamped sizes, sets positions to 0..k-1 and clears done.
//   Both complete at the accepting edge and raise no busy; cmd 3 is ignored.
//   cmd ADVANCE raises busy and runs the microcode program: after the
//   DISPATCH and KCHECK steps the current subset leaves one element per
//   cycle on o_strobe, last marked on the final one. The program then
//   searches the positions right to left (steps SRCH, SRCH_END and SRCH_DEC
//   for each position) and refills the tail. An empty subset gives one
//   result with o_no_element, and an exhausted iteration one result with
//   o_finished.
//   Results are shown for exactly one cycle; the receiver cannot stall them.
//   Config registers (index 0 pick count k, 1 set size n) are written at once
//   through i_cfg_we and are meant to change only while idle.
//   Reset (synchronous, active low) clears sizes, done and positions to i;
//   table contents stay undefined until loaded.

module k_subset_combination_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_cmd,
    input  logic [kscg_pkg::IDX_BITS-1:0]      i_element_index,
    input  logic [kscg_pkg::VALUE_BITS-1:0]    i_element_value,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [kscg_pkg::SIZE_BITS-1:0]     i_cfg_data,
    output logic                               o_strobe,
    output logic [kscg_pkg::IDX_BITS-1:0]      o_position,
    output logic [kscg_pkg::IDX_BITS-1:0]      o_chosen_index,
    output logic [kscg_pkg::VALUE_BITS-1:0]    o_chosen_value,
    output logic                               o_last,
    output logic                               o_finished,
    output logic                               o_no_element
);

    logic             w_accept, w_go;
    kscg_pkg::t_ctrl  w_ctrl;
    kscg_pkg::t_flags w_flags;

    assign w_accept = start && !busy;
    assign w_go     = w_accept && (kscg_pkg::t_cmd'(i_cmd) == kscg_pkg::CMD_ADVANCE);

    kscg_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl),
        .o_busy  (busy)
    );

    kscg_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (kscg_pkg::t_cfg_reg'(i_cfg_index)),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (w_accept),
        .i_cmd           (i_cmd),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_ctrl          (w_ctrl),
        .o_flags         (w_flags),
        .o_strobe        (o_strobe),
        .o_position      (o_position),
        .o_chosen_index  (o_chosen_index),
        .o_chosen_value  (o_chosen_value),
        .o_last          (o_last),
        .o_finished      (o_finished),
        .o_no_element    (o_no_element)
    );

    a_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> busy)
        else $error("advance request did not start the program");

    a_fin_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_finished |-> !o_last && !o_no_element)
        else $error("finished result carries other flags");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_no_element |-> o_last)
        else $error("empty subset result not marked last");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !o_strobe)
        else $error("result without a running program");

endmodule

// ===== hdl/kscg_sequencer.sv =====
// kscg_sequencer: step counter and microcode ROM of the generator.
// Depends on kscg_pkg.

module kscg_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  kscg_pkg::t_flags i_flags,
    output kscg_pkg::t_ctrl  o_ctrl,
    output logic            o_busy
);

    logic            r_busy, n_busy;
    kscg_pkg::t_pc   r_pc, n_pc;
    kscg_pkg::t_ctrl w_word;
    logic            w_cond, w_taken;

    assign w_word = kscg_pkg::f_ucode(r_pc);

    always_comb begin
        case (w_word.cond)
            kscg_pkg::C_NEVER:  w_cond = 1'b0;
            kscg_pkg::C_ALWAYS: w_cond = 1'b1;
            kscg_pkg::C_DONE:   w_cond = i_flags.done;
            kscg_pkg::C_KZERO:  w_cond = i_flags.kzero;
            kscg_pkg::C_LASTP:  w_cond = i_flags.lastp;
            kscg_pkg::C_ATMAX:  w_cond = i_flags.atmax;
            kscg_pkg::C_PZERO:  w_cond = i_flags.pzero;
            default:            w_cond = 1'b0;
        endcase
        w_taken = w_cond ^ w_word.inv;
    end

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (r_busy) begin
            if (w_taken) begin
                n_pc = w_word.target;
            end else if (w_word.fin) begin
                n_busy = 1'b0;
            end else begin
                n_pc = r_pc + kscg_pkg::t_pc'(1);
            end
        end else if (i_go) begin
            n_busy = 1'b1;
            n_pc   = kscg_pkg::PC_DISPATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= kscg_pkg::PC_DISPATCH;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_ctrl = r_busy ? w_word : kscg_pkg::CTRL_NOP;
    assign o_busy = r_busy;

endmodule

// ===== hdl/kscg_datapath.sv =====
// kscg_datapath: element table, position registers, pointer, sizes and
// result registers, driven by the control word. Depends on kscg_pkg.

module kscg_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  kscg_pkg::t_cfg_reg                   i_cfg_index,
    input  kscg_pkg::t_size                      i_cfg_data,
    input  logic                                 i_accept,
    input  logic [1:0]                           i_cmd,
    input  logic [kscg_pkg::IDX_BITS-1:0]        i_element_index,
    input  logic [kscg_pkg::VALUE_BITS-1:0]      i_element_value,
    input  kscg_pkg::t_ctrl                      i_ctrl,
    output kscg_pkg::t_flags                     o_flags,
    output logic                                 o_strobe,
    output logic [kscg_pkg::IDX_BITS-1:0]        o_position,
    output logic [kscg_pkg::IDX_BITS-1:0]        o_chosen_index,
    output logic [kscg_pkg::VALUE_BITS-1:0]      o_chosen_value,
    output logic                                 o_last,
    output logic                                 o_finished,
    output logic                                 o_no_element
);

    localparam int IB = kscg_pkg::IDX_BITS;
    localparam int SB = kscg_pkg::SIZE_BITS;

    logic [kscg_pkg::VALUE_BITS-1:0] r_table [kscg_pkg::MAX_ELEMENTS];
    logic [kscg_pkg::VALUE_BITS-1:0] r_rd_data;
    logic [IB-1:0]  r_positions [kscg_pkg::MAX_SUBSET];
    kscg_pkg::t_size r_pick_count, r_set_size, r_k, r_n, r_ptr, n_ptr, r_v, n_v;
    kscg_pkg::t_size w_n_clamp, w_k_clamp;
    logic           r_done;
    logic [IB-1:0]  w_idx, w_pos_rd;
    logic           w_load, w_restart;
    logic           r_strobe, r_last, r_fin, r_none, r_val_en;
    logic [IB-1:0]  r_opos, r_oidx;

    assign w_idx    = r_ptr[IB-1:0];
    assign w_pos_rd = r_positions[w_idx];
    assign w_load    = i_accept && (kscg_pkg::t_cmd'(i_cmd) == kscg_pkg::CMD_LOAD);
    assign w_restart = i_accept && (kscg_pkg::t_cmd'(i_cmd) == kscg_pkg::CMD_RESTART);

    assign w_n_clamp = (r_set_size > SB'(kscg_pkg::MAX_ELEMENTS)) ?
                       SB'(kscg_pkg::MAX_ELEMENTS) : r_set_size;
    assign w_k_clamp = (r_pick_count > w_n_clamp) ? w_n_clamp : r_pick_count;

    assign o_flags.done  = r_done;
    assign o_flags.kzero = (r_k == '0);
    assign o_flags.lastp = ((r_ptr + SB'(1)) == r_k);
    // position at its maximum: pos + k == n + ptr
    assign o_flags.atmax = (({2'b00, w_pos_rd} + {1'b0, r_k}) ==
                            ({1'b0, r_n} + {1'b0, r_ptr}));
    assign o_flags.pzero = (r_ptr == '0);

    always_comb begin
        case (i_ctrl.ptr_op)
            kscg_pkg::PTR_HOLD: n_ptr = r_ptr;
            kscg_pkg::PTR_ZERO: n_ptr = '0;
            kscg_pkg::PTR_INC:  n_ptr = r_ptr + SB'(1);
            kscg_pkg::PTR_DEC:  n_ptr = r_ptr - SB'(1);
            kscg_pkg::PTR_KM1:  n_ptr = r_k - SB'(1);
            default:            n_ptr = r_ptr;
        endcase
        case (i_ctrl.v_op)
            kscg_pkg::V_HOLD: n_v = r_v;
            kscg_pkg::V_LOAD: n_v = {1'b0, w_pos_rd} + SB'(1);
            kscg_pkg::V_INC:  n_v = r_v + SB'(1);
            default:          n_v = r_v;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_table[i_element_index] <= i_element_value;
        end
        r_rd_data <= r_table[w_pos_rd];
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_v   <= n_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick_count  <= '0;
            r_set_size    <= '0;
            r_k           <= '0;
            r_n           <= '0;
            r_done        <= 1'b0;
            for (int i = 0; i < kscg_pkg::MAX_SUBSET; i++) begin
                r_positions[i] <= IB'(i);
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    kscg_pkg::CFG_PICK_COUNT: r_pick_count <= i_cfg_data;
                    kscg_pkg::CFG_SET_SIZE:   r_set_size   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_restart) begin
                r_k    <= w_k_clamp;
                r_n    <= w_n_clamp;
                r_done <= 1'b0;
                for (int i = 0; i < kscg_pkg::MAX_SUBSET; i++) begin
                    r_positions[i] <= IB'(i);
                end
            end else begin
                if (i_ctrl.set_done) begin
                    r_done <= 1'b1;
                end
                if (i_ctrl.pos_wr) begin
                    r_positions[w_idx] <= r_v[IB-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_ctrl.emit != kscg_pkg::EM_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_opos   <= '0;
        r_oidx   <= '0;
        r_last   <= 1'b0;
        r_fin    <= 1'b0;
        r_none   <= 1'b0;
        r_val_en <= 1'b0;
        case (i_ctrl.emit)
            kscg_pkg::EM_ELEM: begin
                r_opos   <= w_idx;
                r_oidx   <= w_pos_rd;
                r_last   <= o_flags.lastp;
                r_val_en <= 1'b1;
            end
            kscg_pkg::EM_EMPTY: begin
                r_last <= 1'b1;
                r_none <= 1'b1;
            end
            kscg_pkg::EM_FIN: begin
                r_fin <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_strobe       = r_strobe;
    assign o_position     = r_opos;
    assign o_chosen_index = r_oidx;
    assign o_chosen_value = r_val_en ? r_rd_data : '0;
    assign o_last         = r_last;
    assign o_finished     = r_fin;
    assign o_no_element   = r_none;

endmodule
